@@ rtl/lsmt_pkg.sv @@
package lsmt_pkg;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_FLOOD   = 2'd0,
    ACT_DROP    = 2'd1,
    ACT_FORWARD = 2'd2,
    ACT_SWEEP   = 2'd3
  } action_t;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_AGE   = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_PORT_COUNT = 1'b0,
    REG_MAX_AGE    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [4:0]  in_port;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  out_port;
    logic [15:0] flood_mask;
  } out_item_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [4:0]  port;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_L_RD,
    S_L_CHK,
    S_L_APPEND,
    S_O_RD,
    S_O_CHK,
    S_E_RD,
    S_E_CPY,
    S_D_RD,
    S_D_CHK,
    S_A_RD,
    S_A_CHK,
    S_A_LRD,
    S_A_CPY,
    S_OUT
  } state_t;

endpackage

@@ rtl/lsmt_ram.sv @@
module lsmt_ram #(
  parameter int WIDTH = 85,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/learning_switch_mac_table.sv @@
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | in_item_t  (cmd, macs, port, now)
// rsp     | out       | rsp_valid/rsp_ready  | out_item_t (action, port, mask)
// cfg     | in        | APB psel/penable     | port_count @0x0, max_age @0x4
//
// One item at a time; req_ready is high only while the sequencer is idle.
// Each table entry takes a read state and a check state per scan (one RAM read port, registered).
// Frame: a learning scan of the table, then a lookup scan of it; a learn miss
// on a full table adds an oldest-entry scan and the refill.
// Aging sweep: a kept entry takes a read and a check; a removed entry adds a read of the last entry and a copy.
// Synchronous reset empties the table (count zero); no clearing pass.
// A result waits in the output register; the sequencer stalls in S_OUT until the previous result is taken.
module learning_switch_mac_table #(
  parameter int ENTRIES   = 64,
  parameter int MAX_PORTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  lsmt_pkg::in_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output lsmt_pkg::out_item_t rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lsmt_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LIM = (MAX_PORTS < 16) ? MAX_PORTS : 16;

  state_t state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] best, best_next;
  logic [31:0] best_age, best_age_next;
  in_item_t item;
  out_item_t res, res_next;
  logic [4:0] port_count;
  logic [31:0] max_age;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rd;
  logic [31:0] age;
  logic [15:0] mask;
  logic [CW-1:0] last;

  lsmt_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  // shared age unit
  assign age  = item.now - rd.stamp;
  assign last = cnt - CW'(1);

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      mask[k] = (5'(k + 1) <= port_count) && (k + 1 <= LIM) && (5'(k + 1) != item.in_port);
    end
  end

  // config port
  assign pready = 1'b1;
  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_PORT_COUNT: prdata = {27'd0, port_count};
      REG_MAX_AGE:    prdata = max_age;
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_count <= 5'd16;
      max_age    <= 32'd300;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[2]))
        REG_PORT_COUNT: port_count <= pwdata[4:0];
        REG_MAX_AGE:    max_age    <= pwdata;
        default:        ;
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (req_valid) begin
        state_next = (cmd_t'(req.cmd) == CMD_AGE) ? S_A_RD : S_L_RD;
      end
      S_L_RD: begin
        if (idx == cnt) begin
          state_next = (cnt == CW'(ENTRIES)) ? S_O_RD : S_L_APPEND;
        end else begin
          state_next = S_L_CHK;
        end
      end
      S_L_CHK:    state_next = (rd.mac == item.src_mac) ? S_D_RD : S_L_RD;
      S_L_APPEND: state_next = S_D_RD;
      S_O_RD:     state_next = (idx == cnt) ? S_E_RD : S_O_CHK;
      S_O_CHK:    state_next = S_O_RD;
      S_E_RD:     state_next = S_E_CPY;
      S_E_CPY:    state_next = S_L_APPEND;
      S_D_RD: begin
        if (item.dst_mac == BCAST_MAC || idx == cnt) begin
          state_next = S_OUT;
        end else begin
          state_next = S_D_CHK;
        end
      end
      S_D_CHK:    state_next = (rd.mac == item.dst_mac) ? S_OUT : S_D_RD;
      S_A_RD:     state_next = (idx == cnt) ? S_OUT : S_A_CHK;
      S_A_CHK:    state_next = (age >= max_age) ? S_A_LRD : S_A_RD;
      S_A_LRD:    state_next = S_A_CPY;
      S_A_CPY:    state_next = S_A_RD;
      S_OUT:      if (!rsp_valid || rsp_ready) begin
        state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    idx_next      = idx;
    cnt_next      = cnt;
    best_next     = best;
    best_age_next = best_age;
    res_next      = res;
    we            = 1'b0;
    waddr         = idx[AW-1:0];
    wdata         = '{mac: item.src_mac, port: item.in_port, stamp: item.now};
    raddr         = idx[AW-1:0];
    case (state)
      S_IDLE:     idx_next = '0;
      S_L_RD: begin
        if (idx == cnt) begin
          idx_next = '0;
        end
      end
      S_L_CHK: begin
        if (rd.mac == item.src_mac) begin
          we       = 1'b1;
          idx_next = '0;
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      S_L_APPEND: begin
        we       = 1'b1;
        waddr    = cnt[AW-1:0];
        cnt_next = cnt + CW'(1);
        idx_next = '0;
      end
      S_O_CHK: begin
        if (idx == '0 || age > best_age) begin
          best_next     = idx[AW-1:0];
          best_age_next = age;
        end
        idx_next = idx + CW'(1);
      end
      S_E_RD:     raddr = last[AW-1:0];
      S_E_CPY: begin
        // move the last entry into the evicted slot
        we       = 1'b1;
        waddr    = best;
        wdata    = rd;
        cnt_next = last;
      end
      S_D_RD: begin
        if (item.dst_mac == BCAST_MAC || idx == cnt) begin
          res_next = '{action: ACT_FLOOD, out_port: 5'd0, flood_mask: mask};
        end
      end
      S_D_CHK: begin
        if (rd.mac == item.dst_mac) begin
          if (rd.port == item.in_port) begin
            res_next = '{action: ACT_DROP, out_port: 5'd0, flood_mask: 16'd0};
          end else begin
            res_next = '{action: ACT_FORWARD, out_port: rd.port, flood_mask: 16'd0};
          end
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      S_A_RD: begin
        if (idx == cnt) begin
          res_next = '{action: ACT_SWEEP, out_port: 5'd0, flood_mask: 16'd0};
        end
      end
      S_A_CHK: begin
        if (age < max_age) begin
          idx_next = idx + CW'(1);
        end
      end
      S_A_LRD:    raddr = last[AW-1:0];
      S_A_CPY: begin
        // refill the freed slot and check it again
        we       = 1'b1;
        wdata    = rd;
        cnt_next = last;
      end
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_OUT && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    best     <= best_next;
    best_age <= best_age_next;
    res      <= res_next;
    if (req_valid && req_ready) begin
      item <= req;
    end
    if (state == S_OUT && (!rsp_valid || rsp_ready)) begin
      rsp <= res;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(ENTRIES)) else $error("table count above capacity");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    state == S_E_RD |-> cnt == CW'(ENTRIES)) else $error("eviction on a table that is not full");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state != S_IDLE) else $error("item accepted but idle");

  a_sweep_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.action == ACT_SWEEP) |-> (rsp.out_port == 5'd0 && rsp.flood_mask == 16'd0))
    else $error("sweep result carries port data");

endmodule
